[rtl/cxahc_pkg.sv]
// Shared types and constants for the chained XOR/add header cipher.
// No dependencies; every other file in rtl/ imports this package.
package cxahc_pkg;

   localparam int BYTE_W      = 8;
   localparam int FUNC_W      = 2;
   localparam int INDEX_W     = 6;
   localparam int KEY_LEN_W   = 6;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   // Function select codes carried on the request channel
   localparam logic [FUNC_W-1:0] FUNC_INIT    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ENCRYPT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DECRYPT = 2'd2;

   // Register map: key words sit at 0..4, key length follows
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH = 3'd5;

   localparam logic [KEY_LEN_W-1:0] KEY_LENGTH_RESET = 6'd40;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [INDEX_W-1:0] index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_KEY,
      ST_CALC,
      ST_RESP
   } state_type;

   // Remainder unit control and status
   typedef struct packed {
      logic      start;
      index_type dividend;
      index_type divisor;
   } mod_req_type;

   typedef struct packed {
      logic      done;
      index_type remainder;
   } mod_rsp_type;

endpackage

[rtl/cxahc_req_if.sv]
// Request channel interface: valid/ready plus one header byte and its controls.
// Depends on cxahc_pkg.
interface cxahc_req_if;
   import cxahc_pkg::*;

   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   byte_type          data_in;
   logic              length_ok;

   modport source (output valid, func, data_in, length_ok, input ready);
   modport sink   (input valid, func, data_in, length_ok, output ready);
endinterface

[rtl/cxahc_rsp_if.sv]
// Response channel interface: valid/ready plus the transformed byte.
// Depends on cxahc_pkg.
interface cxahc_rsp_if;
   import cxahc_pkg::*;

   logic     valid;
   logic     ready;
   byte_type data_out;
   logic     processed;

   modport source (output valid, data_out, processed, input ready);
   modport sink   (input valid, data_out, processed, output ready);
endinterface

[rtl/cxahc_mod.sv]
// Bit-serial restoring remainder unit: dividend mod divisor, one bit per cycle.
// Depends on cxahc_pkg.
module cxahc_mod (
   input  logic                  clock,
   input  logic                  reset,
   input  cxahc_pkg::mod_req_type req_i,
   output cxahc_pkg::mod_rsp_type rsp_o
);
   import cxahc_pkg::*;

   localparam int CNT_W = $clog2(INDEX_W + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   index_type        num_ff, num_in;
   index_type        div_ff, div_in;
   index_type        rem_ff, rem_in;
   logic [INDEX_W:0] trial;
   logic [INDEX_W:0] diff;

   always_comb begin
      trial   = {rem_ff, num_ff[INDEX_W-1]};
      diff    = trial - {1'b0, div_ff};
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      done_in = 1'b0;
      if (req_i.start) begin
         cnt_in = CNT_W'(INDEX_W);
         num_in = req_i.dividend;
         div_in = req_i.divisor;
         rem_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         num_in  = num_ff << 1;
         // partial remainder stays below the divisor, so it fits INDEX_W bits
         rem_in  = (trial >= {1'b0, div_ff}) ? diff[INDEX_W-1:0] : trial[INDEX_W-1:0];
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign rsp_o.done      = done_ff;
   assign rsp_o.remainder = rem_ff;

endmodule

[rtl/chained_xor_add_header_cipher.sv]
// Top level of the chained XOR/add header cipher: sequencer, key store, chain state.
// Depends on cxahc_pkg, cxahc_req_if, cxahc_rsp_if and cxahc_mod.
//
//   channel   | direction | handshake          | word contents
//   ----------+-----------+--------------------+--------------------------------
//   req_port  | in        | valid/ready        | func, data_in, length_ok
//   rsp_port  | out       | valid/ready        | data_out, processed
//   csr_*     | in        | csr_we, no wait    | csr_index, csr_wdata
//
// Sequence: an encrypt or decrypt word that is processed passes from accept
// through idle, the bit-serial remainder unit (one index bit per step, then its
// done flag), the key store read, the byte math, and the response presented.
// Init and pass-through words go from idle straight to the response.
// One word is in flight at a time; req_port.ready is low until the response is taken.
// Synchronous active-high reset clears key, key length (to 40), chain state and
// the initialized flag. A stalled response simply holds in its output register.
module chained_xor_add_header_cipher #(
   parameter int MAX_KEY_BYTES = 40
) (
   input  logic                                 clock,
   input  logic                                 reset,
   cxahc_req_if.sink                            req_port,
   cxahc_rsp_if.source                          rsp_port,
   input  logic                                 csr_we,
   input  logic [cxahc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cxahc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import cxahc_pkg::*;

   // key words actually backed by storage
   localparam int NUM_WORDS = (MAX_KEY_BYTES + 7) / 8;
   localparam int WSEL_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(MAX_KEY_BYTES);

   state_type        state_ff, state_in;

   // architectural chain state
   logic             ready_flag_ff;
   index_type        send_index_ff;
   byte_type         send_last_ff;
   index_type        recv_index_ff;
   byte_type         recv_last_ff;

   // configuration
   logic [CSR_DATA_W-1:0] key_mem_ff [NUM_WORDS];
   logic [KEY_LEN_W-1:0]  key_len_ff;

   // per-word working registers
   logic [FUNC_W-1:0] func_ff;
   byte_type          data_ff;
   index_type         rem_ff;
   byte_type          key_byte_ff;
   byte_type          out_data_ff;
   logic              out_proc_ff;

   logic              accept;
   logic              work;
   logic [KEY_LEN_W-1:0] eff_len;
   byte_type          calc_byte;
   mod_req_type       mod_req;
   mod_rsp_type       mod_rsp;

   cxahc_mod u_mod (
      .clock (clock),
      .reset (reset),
      .req_i (mod_req),
      .rsp_o (mod_rsp)
   );

   // length 0 acts as 1, anything past the store acts as its size
   always_comb begin
      if (key_len_ff == '0)
         eff_len = KEY_LEN_W'(1);
      else if (key_len_ff > MAX_LEN)
         eff_len = MAX_LEN;
      else
         eff_len = key_len_ff;
   end

   assign accept = req_port.valid && req_port.ready;
   // a word is transformed only when initialized, long enough, and enc/dec
   assign work   = ((req_port.func == FUNC_ENCRYPT) || (req_port.func == FUNC_DECRYPT))
                   && ready_flag_ff && req_port.length_ok;

   // encrypt: (d ^ k) + last ; decrypt: (d - last) ^ k
   always_comb begin
      if (func_ff == FUNC_ENCRYPT)
         calc_byte = (data_ff ^ key_byte_ff) + send_last_ff;
      else
         calc_byte = (data_ff - recv_last_ff) ^ key_byte_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept)
               state_in = work ? ST_MOD : ST_RESP;
         end
         ST_MOD: begin
            if (mod_rsp.done)
               state_in = ST_KEY;
         end
         ST_KEY:  state_in = ST_CALC;
         ST_CALC: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_port.ready)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_port.ready     = (state_ff == ST_IDLE);
      rsp_port.valid     = (state_ff == ST_RESP);
      rsp_port.data_out  = out_data_ff;
      rsp_port.processed = out_proc_ff;
      mod_req.start      = accept && work;
      mod_req.dividend   = (req_port.func == FUNC_ENCRYPT) ? send_index_ff : recv_index_ff;
      mod_req.divisor    = eff_len;
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ready_flag_ff <= 1'b0;
         send_index_ff <= '0;
         send_last_ff  <= '0;
         recv_index_ff <= '0;
         recv_last_ff  <= '0;
         key_len_ff    <= KEY_LENGTH_RESET;
         for (int i = 0; i < NUM_WORDS; i++)
            key_mem_ff[i] <= '0;
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            if (csr_index < CSR_INDEX_W'(NUM_WORDS))
               key_mem_ff[WSEL_W'(csr_index)] <= csr_wdata;
            else if (csr_index == CSR_KEY_LENGTH)
               key_len_ff <= csr_wdata[KEY_LEN_W-1:0];
         end

         if (accept && (req_port.func == FUNC_INIT)) begin
            ready_flag_ff <= 1'b1;
            send_index_ff <= '0;
            send_last_ff  <= '0;
            recv_index_ff <= '0;
            recv_last_ff  <= '0;
         end

         if (state_ff == ST_CALC) begin
            // remainder < effective key length, so +1 never wraps the index
            if (func_ff == FUNC_ENCRYPT) begin
               send_index_ff <= rem_ff + 1'b1;
               send_last_ff  <= calc_byte;
            end else begin
               recv_index_ff <= rem_ff + 1'b1;
               recv_last_ff  <= data_ff;
            end
         end
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff     <= req_port.func;
         data_ff     <= req_port.data_in;
         out_data_ff <= req_port.data_in;
         out_proc_ff <= 1'b0;
      end
      if ((state_ff == ST_MOD) && mod_rsp.done)
         rem_ff <= mod_rsp.remainder;
      // registered key store read: word = idx/8, byte lane = idx%8
      if (state_ff == ST_KEY)
         key_byte_ff <= key_mem_ff[WSEL_W'(rem_ff[INDEX_W-1:3])][{rem_ff[2:0], 3'b000} +: BYTE_W];
      if (state_ff == ST_CALC) begin
         out_data_ff <= calc_byte;
         out_proc_ff <= 1'b1;
      end
   end

endmodule
